>>> hdl/dns_response_record_parser_assert.svh
// Assertion macros for the DNS response record parser.
// Expects clk_i and rst_ni in the scope of use.
`ifndef DNS_RESPONSE_RECORD_PARSER_ASSERT_SVH
`define DNS_RESPONSE_RECORD_PARSER_ASSERT_SVH

// Same-cycle implication
`define DRRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DRRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/drrp_pkg.sv
// Shared types and constants for the DNS response record parser.
// No dependencies.
package drrp_pkg;

  localparam int unsigned MaxPacketBytes = 1024;
  localparam int unsigned PosW           = $clog2(MaxPacketBytes + 1);
  localparam int unsigned HeaderBytes    = 12;
  localparam int unsigned QueueDepth     = 4;
  localparam int unsigned QPtrW          = $clog2(QueueDepth);

  localparam logic [7:0]  PtrMask        = 8'hC0;
  localparam logic [7:0]  LenMask        = 8'h3F;
  localparam logic [3:0]  RcodeMask      = 4'd15;
  localparam logic [1:0]  SecQuestion    = 2'd3;
  localparam logic [15:0] QFixedBytes    = 16'd4;
  localparam logic [15:0] RFixedLast     = 16'd9;
  localparam logic [15:0] RFixedHdrBytes = 16'd8;
  localparam logic [15:0] TypeA          = 16'd1;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_RECORD,
    KIND_END_OK,
    KIND_END_TRUNC
  } kind_e;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_LABEL,
    PH_POINTER,
    PH_QFIXED,
    PH_RFIXED,
    PH_RDATA,
    PH_DONE
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  section;
    logic        aa;
    logic        tc;
    logic [3:0]  rcode;
    logic [15:0] f_type;
    logic [15:0] f_class;
    logic [15:0] f_len;
    logic [31:0] f_ttl;
    logic [31:0] f_addr;
  } result_t;

  // One parsed byte's worth of output: an optional header/record result,
  // optionally followed by the end-of-message result.
  typedef struct packed {
    logic    has_main;
    result_t main;
    logic    has_end;
    logic    end_ok;
  } event_t;

endpackage

>>> hdl/drrp_front.sv
// Byte parser front end: walks the DNS message and emits result events.
// Depends on drrp_pkg.
module drrp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          packet_byte_i,
  input  logic                end_of_packet_i,
  input  logic                q_full_i,
  output logic                ev_push_o,
  output drrp_pkg::event_t    ev_o
);

  localparam logic [drrp_pkg::PosW-1:0] PosMax  = drrp_pkg::PosW'(drrp_pkg::MaxPacketBytes);
  localparam logic [drrp_pkg::PosW-1:0] PosOne  = drrp_pkg::PosW'(1);
  localparam logic [drrp_pkg::PosW-1:0] PosAa   = drrp_pkg::PosW'(2);
  localparam logic [drrp_pkg::PosW-1:0] PosRc   = drrp_pkg::PosW'(3);
  localparam logic [drrp_pkg::PosW-1:0] PosCnt  = drrp_pkg::PosW'(4);
  localparam logic [drrp_pkg::PosW-1:0] PosLast = drrp_pkg::PosW'(drrp_pkg::HeaderBytes - 1);

  drrp_pkg::phase_e            phase_q, phase_d, phase_n;
  logic [drrp_pkg::PosW-1:0]   pos_q, pos_d;
  logic [15:0]                 left_q, left_d;
  logic [1:0]                  sec_q, sec_d;
  logic [15:0]                 skip_q, skip_d;
  logic [15:0]                 fs_q, fs_d;
  logic [15:0]                 cnt_q [4];
  logic [15:0]                 cnt_d [4];
  logic [63:0]                 rf0_q, rf0_d;
  logic [15:0]                 len_q, len_d;
  logic [31:0]                 addr_q, addr_d;
  logic [5:0]                  flags_q, flags_d;

  logic        accept, consume;
  logic        emit_hdr, emit_rec;
  logic        name_done, item_done, start_grp;
  logic [2:0]  grp_from;
  logic [2:0]  next_grp;
  logic [15:0] skip_dec, left_dec, rd_n, new_len;
  logic [3:0]  hdr_off;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign consume    = accept && (pos_q < PosMax);
  assign skip_dec   = skip_q - {15'd0, (skip_q != 16'd0)};
  assign left_dec   = left_q - {15'd0, (left_q != 16'd0)};
  assign rd_n       = len_q - skip_q;
  assign new_len    = {fs_q[7:0], packet_byte_i};
  assign hdr_off    = pos_q[3:0] - 4'd4;

  // Next state
  always_comb begin
    phase_n   = phase_q;
    pos_d     = pos_q;
    left_d    = left_q;
    sec_d     = sec_q;
    skip_d    = skip_q;
    fs_d      = fs_q;
    cnt_d     = cnt_q;
    rf0_d     = rf0_q;
    len_d     = len_q;
    addr_d    = addr_q;
    flags_d   = flags_q;
    emit_hdr  = 1'b0;
    emit_rec  = 1'b0;
    name_done = 1'b0;
    item_done = 1'b0;
    start_grp = 1'b0;
    grp_from  = 3'd0;
    next_grp  = (sec_q == drrp_pkg::SecQuestion) ? 3'd1 : ({1'b0, sec_q} + 3'd2);

    if (consume) begin
      pos_d = pos_q + PosOne;
      unique case (phase_q)
        drrp_pkg::PH_HEADER: begin
          if (pos_q == PosAa) begin
            flags_d[5:4] = {packet_byte_i[2], packet_byte_i[1]};
          end else if (pos_q == PosRc) begin
            flags_d[3:0] = packet_byte_i[3:0] & drrp_pkg::RcodeMask;
          end else if (pos_q >= PosCnt && pos_q <= PosLast) begin
            fs_d = {fs_q[7:0], packet_byte_i};
            if (pos_q[0]) begin
              cnt_d[hdr_off[2:1]] = {fs_q[7:0], packet_byte_i};
            end
          end
          if (pos_q == PosLast) begin
            emit_hdr  = 1'b1;
            start_grp = 1'b1;
            grp_from  = 3'd0;
          end
        end
        drrp_pkg::PH_NAME: begin
          if (packet_byte_i == 8'd0) begin
            name_done = 1'b1;
          end else if ((packet_byte_i & drrp_pkg::PtrMask) != 8'd0) begin
            phase_n = drrp_pkg::PH_POINTER;
          end else begin
            skip_d  = {8'd0, packet_byte_i & drrp_pkg::LenMask};
            phase_n = drrp_pkg::PH_LABEL;
          end
        end
        drrp_pkg::PH_LABEL: begin
          skip_d = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_n = drrp_pkg::PH_NAME;
          end
        end
        drrp_pkg::PH_POINTER: begin
          name_done = 1'b1;
        end
        drrp_pkg::PH_QFIXED: begin
          skip_d = skip_dec;
          if (skip_dec == 16'd0) begin
            item_done = 1'b1;
          end
        end
        drrp_pkg::PH_RFIXED: begin
          if (skip_q < drrp_pkg::RFixedHdrBytes) begin
            rf0_d = {rf0_q[55:0], packet_byte_i};
          end else begin
            fs_d = {fs_q[7:0], packet_byte_i};
          end
          skip_d = skip_q + 16'd1;
          if (skip_q >= drrp_pkg::RFixedLast) begin
            len_d  = new_len;
            addr_d = 32'd0;
            skip_d = new_len;
            if (new_len == 16'd0) begin
              emit_rec  = 1'b1;
              item_done = 1'b1;
            end else begin
              phase_n = drrp_pkg::PH_RDATA;
            end
          end
        end
        drrp_pkg::PH_RDATA: begin
          if (rf0_q[63:48] == drrp_pkg::TypeA && rd_n < 16'd4) begin
            case (rd_n[1:0])
              2'd0:    addr_d[31:24] = addr_q[31:24] | packet_byte_i;
              2'd1:    addr_d[23:16] = addr_q[23:16] | packet_byte_i;
              2'd2:    addr_d[15:8]  = addr_q[15:8]  | packet_byte_i;
              default: addr_d[7:0]   = addr_q[7:0]   | packet_byte_i;
            endcase
          end
          skip_d = skip_dec;
          if (skip_dec == 16'd0) begin
            emit_rec  = 1'b1;
            item_done = 1'b1;
          end
        end
        default: ;
      endcase

      if (name_done) begin
        fs_d = 16'd0;
        if (sec_q == drrp_pkg::SecQuestion) begin
          skip_d  = drrp_pkg::QFixedBytes;
          phase_n = drrp_pkg::PH_QFIXED;
        end else begin
          skip_d  = 16'd0;
          rf0_d   = 64'd0;
          len_d   = 16'd0;
          addr_d  = 32'd0;
          phase_n = drrp_pkg::PH_RFIXED;
        end
      end

      if (item_done) begin
        left_d = left_dec;
        if (left_dec == 16'd0) begin
          start_grp = 1'b1;
          grp_from  = next_grp;
        end else begin
          phase_n = drrp_pkg::PH_NAME;
        end
      end

      // first non-empty group from grp_from on; lowest index wins
      if (start_grp) begin
        phase_n = drrp_pkg::PH_DONE;
        for (int g = 3; g >= 0; g--) begin
          if (3'(g) >= grp_from && cnt_d[g] != 16'd0) begin
            left_d  = cnt_d[g];
            sec_d   = (g == 0) ? drrp_pkg::SecQuestion : 2'(g - 1);
            phase_n = drrp_pkg::PH_NAME;
          end
        end
      end
    end

    phase_d = phase_n;
    if (accept && end_of_packet_i) begin
      phase_d = drrp_pkg::PH_HEADER;
      pos_d   = '0;
    end
  end

  // Event outputs
  always_comb begin
    ev_o              = '0;
    ev_o.has_main     = emit_hdr | emit_rec;
    ev_o.has_end      = accept & end_of_packet_i;
    ev_o.end_ok       = (phase_n == drrp_pkg::PH_DONE);
    if (emit_hdr) begin
      ev_o.main.kind    = drrp_pkg::KIND_HEADER;
      ev_o.main.aa      = flags_d[5];
      ev_o.main.tc      = flags_d[4];
      ev_o.main.rcode   = flags_d[3:0];
      ev_o.main.f_type  = cnt_d[0];
      ev_o.main.f_class = cnt_d[1];
      ev_o.main.f_len   = cnt_d[2];
      ev_o.main.f_ttl   = {16'd0, cnt_d[3]};
    end else begin
      ev_o.main.kind    = drrp_pkg::KIND_RECORD;
      ev_o.main.section = sec_q;
      ev_o.main.f_type  = rf0_d[63:48];
      ev_o.main.f_class = rf0_d[47:32];
      ev_o.main.f_len   = len_d;
      ev_o.main.f_ttl   = rf0_d[31:0];
      ev_o.main.f_addr  = addr_d;
    end
    ev_push_o = accept & (emit_hdr | emit_rec | end_of_packet_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= drrp_pkg::PH_HEADER;
      pos_q   <= '0;
      left_q  <= '0;
      sec_q   <= '0;
      skip_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      left_q  <= left_d;
      sec_q   <= sec_d;
      skip_q  <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fs_q    <= fs_d;
    cnt_q   <= cnt_d;
    rf0_q   <= rf0_d;
    len_q   <= len_d;
    addr_q  <= addr_d;
    flags_q <= flags_d;
  end

endmodule

>>> hdl/drrp_queue.sv
// Short event queue between the parser and the output stage.
// Depends on drrp_pkg.
module drrp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  drrp_pkg::event_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output drrp_pkg::event_t data_o,
  output logic             empty_o
);

  drrp_pkg::event_t             mem_q [drrp_pkg::QueueDepth];
  logic [drrp_pkg::QPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [drrp_pkg::QPtrW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (drrp_pkg::QPtrW+1)'(drrp_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + (drrp_pkg::QPtrW)'(push_i);
    rd_d  = rd_q + (drrp_pkg::QPtrW)'(pop_i);
    cnt_d = cnt_q + (drrp_pkg::QPtrW+1)'(push_i) - (drrp_pkg::QPtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> hdl/drrp_back.sv
// Output stage: unpacks queued events into single results, one per transfer.
// Depends on drrp_pkg.
module drrp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  drrp_pkg::event_t  q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output drrp_pkg::result_t out_o
);

  drrp_pkg::result_t out_q, out_d;
  logic              valid_q, valid_d;
  logic              pend_q, pend_d;
  logic              pend_ok_q, pend_ok_d;
  logic              load;

  function automatic drrp_pkg::result_t end_result(input logic ok);
    drrp_pkg::result_t r;
    r      = '0;
    r.kind = ok ? drrp_pkg::KIND_END_OK : drrp_pkg::KIND_END_TRUNC;
    return r;
  endfunction

  assign load        = ~valid_q | out_ready_i;
  assign q_pop_o     = load & ~pend_q & ~q_empty_i;
  assign out_valid_o = valid_q;
  assign out_o       = out_q;

  always_comb begin
    out_d     = out_q;
    valid_d   = valid_q;
    pend_d    = pend_q;
    pend_ok_d = pend_ok_q;
    if (load) begin
      valid_d = 1'b0;
      if (pend_q) begin
        out_d   = end_result(pend_ok_q);
        valid_d = 1'b1;
        pend_d  = 1'b0;
      end else if (!q_empty_i) begin
        valid_d = 1'b1;
        if (q_data_i.has_main) begin
          out_d     = q_data_i.main;
          pend_d    = q_data_i.has_end;
          pend_ok_d = q_data_i.end_ok;
        end else begin
          out_d = end_result(q_data_i.end_ok);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    pend_ok_q <= pend_ok_d;
  end

endmodule

>>> hdl/dns_response_record_parser.sv
// DNS response record parser, top level. Uses drrp_pkg, drrp_front, drrp_queue, drrp_back.
// Takes one byte per cycle unless the event queue is full; each result is queued, then registered at the output.
// A byte that ends a header or record and also ends the message gives two results in
// successive output transfers; the 4-entry event queue absorbs that while bytes keep coming.
// Reset (rst_ni low, asynchronous) empties the queue and output and restarts at the header.
`include "dns_response_record_parser_assert.svh"
module dns_response_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  packet_byte_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [1:0]  section_o,
  output logic        authoritative_o,
  output logic        truncated_flag_o,
  output logic [3:0]  response_code_o,
  output logic [15:0] type_or_qdcount_o,
  output logic [15:0] class_or_ancount_o,
  output logic [15:0] length_or_nscount_o,
  output logic [31:0] ttl_or_arcount_o,
  output logic [31:0] ipv4_address_o
);

  drrp_pkg::event_t  ev, q_data;
  drrp_pkg::result_t res;
  logic              ev_push, q_full, q_empty, q_pop;

  drrp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .packet_byte_i   (packet_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .q_full_i        (q_full),
    .ev_push_o       (ev_push),
    .ev_o            (ev)
  );

  drrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_push),
    .data_i  (ev),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  drrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign result_kind_o       = res.kind;
  assign section_o           = res.section;
  assign authoritative_o     = res.aa;
  assign truncated_flag_o    = res.tc;
  assign response_code_o     = res.rcode;
  assign type_or_qdcount_o   = res.f_type;
  assign class_or_ancount_o  = res.f_class;
  assign length_or_nscount_o = res.f_len;
  assign ttl_or_arcount_o    = res.f_ttl;
  assign ipv4_address_o      = res.f_addr;

  `DRRP_ASSERT_SAME(a_no_push_when_full, ev_push, !q_full, "event pushed into full queue")
  `DRRP_ASSERT_SAME(a_no_pop_when_empty, q_pop, !q_empty, "event popped from empty queue")
  `DRRP_ASSERT_NEXT(a_end_queued, in_valid_i && in_ready_o && end_of_packet_i, !q_empty,
                    "message end transfer left no queued event")

endmodule

>>> tb/dns_response_record_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for dns_response_record_parser: byte-stream stimulus, own parser
// model predicting header, record and end results, checked per field. Uses drrp_pkg.
module dns_response_record_parser_tb;
  import drrp_pkg::*;

  typedef logic [7:0] octet_q_t [$];

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic [7:0]  packet_byte = 8'h00;
  logic        eop         = 1'b0;
  logic        out_ready   = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  result_kind;
  logic [1:0]  section;
  logic        authoritative;
  logic        truncated_flag;
  logic [3:0]  response_code;
  logic [15:0] type_or_qdcount;
  logic [15:0] class_or_ancount;
  logic [15:0] length_or_nscount;
  logic [31:0] ttl_or_arcount;
  logic [31:0] ipv4_address;

  dns_response_record_parser uut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .packet_byte_i       (packet_byte),
    .end_of_packet_i     (eop),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .result_kind_o       (result_kind),
    .section_o           (section),
    .authoritative_o     (authoritative),
    .truncated_flag_o    (truncated_flag),
    .response_code_o     (response_code),
    .type_or_qdcount_o   (type_or_qdcount),
    .class_or_ancount_o  (class_or_ancount),
    .length_or_nscount_o (length_or_nscount),
    .ttl_or_arcount_o    (ttl_or_arcount),
    .ipv4_address_o      (ipv4_address)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Parser model state
  phase_e      ph;
  int unsigned pos;
  logic [31:0] shreg;
  logic [15:0] counts [4];
  logic [15:0] group_left;
  logic [1:0]  group_sec;
  logic [15:0] skip_cnt;
  logic [63:0] rec_hi;  // type, class, ttl
  logic [63:0] rec_lo;  // data length in [47:32], address in [31:0]
  logic [5:0]  flags;   // AA, TC, RCODE

  result_t     awaited_results [$];
  result_t     head_result;
  int unsigned mismatch_count = 0;

  bit tx_idle     = 1'b0;
  bit rx_idle     = 1'b0;
  int hold_cycles = 0;

  function automatic void clear_parser();
    ph         = PH_HEADER;
    pos        = 0;
    shreg      = '0;
    group_left = '0;
    group_sec  = '0;
    skip_cnt   = '0;
    rec_hi     = '0;
    rec_lo     = '0;
    flags      = '0;
    for (int i = 0; i < 4; i++) counts[i] = '0;
  endfunction

  // First non-empty group from g on: 0 questions, 1..3 record sections
  function automatic void enter_group(input int g);
    for (int i = g; i < 4; i++) begin
      if (counts[i] != 0) begin
        group_left = counts[i];
        group_sec  = (i == 0) ? SecQuestion : 2'(i - 1);
        ph         = PH_NAME;
        return;
      end
    end
    ph = PH_DONE;
  endfunction

  function automatic void entry_done();
    int nxt;
    nxt = (group_sec == SecQuestion) ? 1 : int'(group_sec) + 2;
    if (group_left != 0) group_left--;
    if (group_left == 0) enter_group(nxt);
    else ph = PH_NAME;
  endfunction

  function automatic void owner_done();
    shreg = '0;
    if (group_sec == SecQuestion) begin
      skip_cnt = QFixedBytes;
      ph       = PH_QFIXED;
    end else begin
      skip_cnt = '0;
      rec_hi   = '0;
      rec_lo   = '0;
      ph       = PH_RFIXED;
    end
  endfunction

  function automatic void push_record();
    result_t r;
    r         = '0;
    r.kind    = KIND_RECORD;
    r.section = group_sec;
    r.f_type  = rec_hi[63:48];
    r.f_class = rec_hi[47:32];
    r.f_ttl   = rec_hi[31:0];
    r.f_len   = rec_lo[47:32];
    r.f_addr  = rec_lo[31:0];
    awaited_results.push_back(r);
    entry_done();
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic last);
    result_t     r;
    int unsigned idx;
    int unsigned n;
    logic [15:0] len;
    if (pos < MaxPacketBytes) begin
      case (ph)
        PH_HEADER: begin
          if (pos == 2) flags[5:4] = {b[2], b[1]};
          else if (pos == 3) flags[3:0] = b[3:0];
          else if (pos >= 4 && pos <= 11) begin
            shreg = {shreg[23:0], b};
            if (pos[0]) counts[(pos - 4) >> 1] = shreg[15:0];
          end
          if (pos == HeaderBytes - 1) begin
            r         = '0;
            r.kind    = KIND_HEADER;
            r.aa      = flags[5];
            r.tc      = flags[4];
            r.rcode   = flags[3:0];
            r.f_type  = counts[0];
            r.f_class = counts[1];
            r.f_len   = counts[2];
            r.f_ttl   = {16'h0000, counts[3]};
            awaited_results.push_back(r);
            enter_group(0);
          end
        end
        PH_NAME: begin
          if (b == 8'h00) owner_done();
          else if ((b & PtrMask) != 0) ph = PH_POINTER;
          else begin
            skip_cnt = {8'h00, b & LenMask};
            ph       = PH_LABEL;
          end
        end
        PH_LABEL: begin
          if (skip_cnt != 0) skip_cnt--;
          if (skip_cnt == 0) ph = PH_NAME;
        end
        PH_POINTER: owner_done();
        PH_QFIXED: begin
          if (skip_cnt != 0) skip_cnt--;
          if (skip_cnt == 0) entry_done();
        end
        PH_RFIXED: begin
          idx = skip_cnt;
          if (idx < RFixedHdrBytes) rec_hi = {rec_hi[55:0], b};
          else shreg = {shreg[23:0], b};
          skip_cnt++;
          if (idx >= RFixedLast) begin
            len      = shreg[15:0];
            rec_lo   = {16'h0000, len, 32'h0};
            skip_cnt = len;
            if (len == 0) push_record();
            else ph = PH_RDATA;
          end
        end
        PH_RDATA: begin
          n = rec_lo[47:32] - skip_cnt;
          if (rec_hi[63:48] == TypeA && n < 4)
            rec_lo[31:0] = rec_lo[31:0] | (32'(b) << (24 - 8 * n));
          if (skip_cnt != 0) skip_cnt--;
          if (skip_cnt == 0) push_record();
        end
        default: ;
      endcase
      pos++;
    end
    if (last) begin
      r = '0;
      if (ph == PH_DONE) r.kind = KIND_END_OK;
      else r.kind = KIND_END_TRUNC;
      awaited_results.push_back(r);
      clear_parser();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 50)
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Predict on every input transfer, check on every output transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) parse_byte(packet_byte, eop);
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, kind", 32'(result_kind), '0);
        end else begin
          head_result = awaited_results.pop_front();
          check_field("result_kind", 32'(result_kind), 32'(head_result.kind));
          check_field("section", 32'(section), 32'(head_result.section));
          check_field("authoritative", 32'(authoritative), 32'(head_result.aa));
          check_field("truncated_flag", 32'(truncated_flag), 32'(head_result.tc));
          check_field("response_code", 32'(response_code), 32'(head_result.rcode));
          check_field("type_or_qdcount", 32'(type_or_qdcount), 32'(head_result.f_type));
          check_field("class_or_ancount", 32'(class_or_ancount), 32'(head_result.f_class));
          check_field("length_or_nscount", 32'(length_or_nscount), 32'(head_result.f_len));
          check_field("ttl_or_arcount", ttl_or_arcount, head_result.f_ttl);
          check_field("ipv4_address", ipv4_address, head_result.f_addr);
        end
      end
    end
  end

  // Result side: random stall bursts, or a long hold-off when one is requested
  initial begin : receiver
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (tx_idle && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    packet_byte <= b;
    eop         <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_packet(input octet_q_t q);
    for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
  endtask

  // Stop offering bytes until every predicted result has been transferred
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  function automatic void put16(ref octet_q_t q, input logic [15:0] v);
    q.push_back(v[15:8]);
    q.push_back(v[7:0]);
  endfunction

  function automatic void put32(ref octet_q_t q, input logic [31:0] v);
    put16(q, v[31:16]);
    put16(q, v[15:0]);
  endfunction

  function automatic void put_header(ref octet_q_t q, input logic [7:0] fl2,
                                     input logic [7:0] fl3, input logic [15:0] qd,
                                     input logic [15:0] an, input logic [15:0] ns,
                                     input logic [15:0] ar);
    put16(q, 16'($urandom));
    q.push_back(fl2);
    q.push_back(fl3);
    put16(q, qd);
    put16(q, an);
    put16(q, ns);
    put16(q, ar);
  endfunction

  function automatic void put_fixed(ref octet_q_t q, input logic [15:0] typ,
                                    input logic [15:0] cls, input logic [31:0] ttl,
                                    input logic [15:0] len);
    put16(q, typ);
    put16(q, cls);
    put32(q, ttl);
    put16(q, len);
  endfunction

  function automatic void put_data(ref octet_q_t q, input int unsigned len);
    repeat (len) q.push_back(8'($urandom));
  endfunction

  // Label run, ended by a root byte or by a two-byte pointer
  function automatic void add_name(ref octet_q_t q);
    int unsigned labels;
    int unsigned len;
    labels = $urandom_range(0, 3);
    repeat (labels) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8);
      q.push_back(8'(len));
      put_data(q, len);
    end
    if ($urandom_range(0, 1) != 0) begin
      q.push_back(8'h00);
    end else begin
      q.push_back(8'($urandom_range(8'h40, 8'hFF)));
      q.push_back(8'($urandom));
    end
  endfunction

  // Returns the number of bytes that precede any trailing junk
  function automatic int unsigned build_random_packet(ref octet_q_t q);
    logic [15:0] cnt [4];
    logic [15:0] typ;
    logic [15:0] len;
    int unsigned bodies;
    int unsigned cut;
    int unsigned useful;
    if ($urandom_range(0, 15) == 0) begin
      put_data(q, $urandom_range(1, 20));
      return q.size();
    end
    cnt[0] = $urandom_range(0, 2);
    cnt[1] = $urandom_range(0, 3);
    cnt[2] = $urandom_range(0, 2);
    cnt[3] = $urandom_range(0, 2);
    // now and then a count far beyond what follows, so the message ends short
    if ($urandom_range(0, 11) == 0) cnt[$urandom_range(0, 3)] = 16'($urandom);
    put_header(q, 8'($urandom), 8'($urandom), cnt[0], cnt[1], cnt[2], cnt[3]);
    for (int g = 0; g < 4; g++) begin
      bodies = (cnt[g] > 4) ? 4 : cnt[g];
      repeat (bodies) begin
        add_name(q);
        if (g == 0) begin
          put32(q, $urandom);
        end else begin
          typ = ($urandom_range(0, 1) != 0) ? TypeA : 16'($urandom);
          len = $urandom_range(0, (typ == TypeA) ? 6 : 10);
          if ($urandom_range(0, 19) == 0) len = $urandom_range(11, 60);
          put_fixed(q, typ, 16'($urandom), $urandom, len);
          put_data(q, len);
        end
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, q.size());
      while (q.size() > cut) void'(q.pop_back());
    end
    useful = q.size();
    if ($urandom_range(0, 3) == 0) put_data(q, $urandom_range(1, 4));
    return useful;
  endfunction

  task automatic random_traffic(input int unsigned goal, input bit with_idling);
    octet_q_t    q;
    int unsigned sent;
    sent = 0;
    while (sent < goal) begin
      q.delete();
      if (with_idling) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      sent += build_random_packet(q);
      send_packet(q);
      if ($urandom_range(0, 15) == 0) drain();
    end
    drain();
  endtask

  task automatic test_header_extremes();
    octet_q_t q;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    // all flag bits set, one question ending in a pointer, one short type A answer
    put_header(q, 8'hFF, 8'hFF, 16'd1, 16'd1, 16'd0, 16'd0);
    q.push_back(8'hC0);
    q.push_back(8'h0C);
    put32(q, 32'hFFFF_FFFF);
    q.push_back(8'd1);
    q.push_back(8'h61);
    q.push_back(8'h00);
    put_fixed(q, TypeA, 16'hFFFF, 32'hFFFF_FFFF, 16'd2);
    q.push_back(8'hFF);
    q.push_back(8'hFF);
    send_packet(q);
    // header only, everything zero; header and end result on the same byte
    q.delete();
    put_header(q, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, 16'd0);
    send_packet(q);
    // message ends inside the header
    q.delete();
    put_data(q, 5);
    send_packet(q);
    drain();
  endtask

  task automatic test_name_forms();
    octet_q_t q;
    put_header(q, 8'h04, 8'h03, 16'd2, 16'd1, 16'd1, 16'd0);
    q.push_back(8'h40);
    q.push_back(8'h11);
    put32(q, $urandom);
    q.push_back(8'd2);
    put_data(q, 2);
    q.push_back(8'h80);
    q.push_back(8'h22);
    put32(q, $urandom);
    q.push_back(8'd3);
    put_data(q, 3);
    q.push_back(8'h00);
    put_fixed(q, 16'h001C, 16'h0001, $urandom, 16'd3);
    put_data(q, 3);
    q.push_back(8'hFF);
    q.push_back(8'hFF);
    put_fixed(q, 16'h0002, 16'h0001, $urandom, 16'd0);
    // bytes after the last record are ignored
    put_data(q, 2);
    send_packet(q);
    drain();
  endtask

  task automatic test_type_a_lengths();
    octet_q_t q;
    put_header(q, 8'h00, 8'h00, 16'd0, 16'd2, 16'd2, 16'd1);
    foreach (q[i]) ;
    for (int len = 0; len <= 4; len++) begin
      q.push_back(8'h00);
      put_fixed(q, TypeA, 16'h0001, $urandom, 16'(len + (len == 4)));
      put_data(q, len + (len == 4));
    end
    send_packet(q);
    drain();
  endtask

  task automatic test_oversize();
    octet_q_t q;
    // data runs past the position limit; the tail is ignored and the record never completes
    put_header(q, 8'($urandom), 8'($urandom), 16'd0, 16'd1, 16'd0, 16'd0);
    q.push_back(8'h00);
    put_fixed(q, 16'h0010, 16'h0001, $urandom, 16'd1010);
    put_data(q, 1010);
    send_packet(q);
    drain();
  endtask

  task automatic test_backpressure();
    octet_q_t q;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    put_header(q, 8'($urandom), 8'($urandom), 16'd0, 16'd10, 16'd0, 16'd2);
    repeat (12) begin
      q.push_back(8'h00);
      put_fixed(q, 16'($urandom), 16'($urandom), $urandom, 16'd0);
    end
    // receiver stalls long enough for the result queue to fill and stop input transfers
    hold_cycles = 300;
    send_packet(q);
    drain();
  endtask

  task automatic test_random_traffic();
    random_traffic(160, 1'b1);
  endtask

  task automatic test_steady_stream();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    random_traffic(70, 1'b0);
  endtask

  initial begin
    clear_parser();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_extremes();
    test_name_forms();
    test_type_a_lengths();
    test_oversize();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();
    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered, count", awaited_results.size(), '0);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
